>>> src/fvr_pkg.sv
// Package with the widths, types and sequencer states of the fraction reduction core.
`default_nettype none
package fvr_pkg;

  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned MAG_WIDTH   = VALUE_WIDTH - 1;
  localparam int unsigned CNT_WIDTH   = $clog2(MAG_WIDTH + 1);

  typedef logic [VALUE_WIDTH-1:0] value_t;
  typedef logic [MAG_WIDTH-1:0]   mag_t;
  typedef logic [CNT_WIDTH-1:0]   cnt_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GCD,
    ST_DIV_NUM,
    ST_DIV_DEN
  } fvr_state_e;

endpackage
`default_nettype wire

>>> src/fvr_gcd.sv
// Binary greatest common divisor unit with one shared subtractor, one step per cycle.
`default_nettype none
module fvr_gcd
  import fvr_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  mag_t a_i,
  input  mag_t b_i,
  output logic done_o,
  output mag_t g_o
);

  mag_t              a_q, a_d;
  mag_t              b_q, b_d;
  cnt_t              k_q, k_d;
  mag_t              g_q, g_d;
  logic              run_q, run_d;
  logic              done_q, done_d;
  logic [MAG_WIDTH:0] diff;

  assign diff = {1'b0, a_q} - {1'b0, b_q};

  always_comb begin
    a_d    = a_q;
    b_d    = b_q;
    k_d    = k_q;
    g_d    = g_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      a_d   = a_i;
      b_d   = b_i;
      k_d   = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      if (a_q == b_q) begin
        g_d    = a_q << k_q;
        run_d  = 1'b0;
        done_d = 1'b1;
      end else if (!a_q[0] && !b_q[0]) begin
        a_d = a_q >> 1;
        b_d = b_q >> 1;
        k_d = k_q + cnt_t'(1);
      end else if (!a_q[0]) begin
        a_d = a_q >> 1;
      end else if (!b_q[0]) begin
        b_d = b_q >> 1;
      end else if (!diff[MAG_WIDTH]) begin
        a_d = diff[MAG_WIDTH-1:0] >> 1;
      end else begin
        b_d = mag_t'(-diff) >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    k_q <= k_d;
    g_q <= g_d;
  end

  assign done_o = done_q;
  assign g_o    = g_q;

endmodule
`default_nettype wire

>>> src/fvr_div.sv
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none
module fvr_div
  import fvr_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  mag_t dividend_i,
  input  mag_t divisor_i,
  output logic done_o,
  output mag_t quot_o
);

  mag_t               quo_q, quo_d;
  mag_t               rem_q, rem_d;
  mag_t               dvs_q, dvs_d;
  cnt_t               cnt_q, cnt_d;
  logic               run_q, run_d;
  logic               done_q, done_d;
  logic [MAG_WIDTH:0] shifted;
  logic               ge;
  logic [MAG_WIDTH:0] sub;

  assign shifted = {rem_q, quo_q[MAG_WIDTH-1]};
  assign ge      = shifted >= {1'b0, dvs_q};
  assign sub     = shifted - {1'b0, dvs_q};

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d = dividend_i;
      rem_d = '0;
      dvs_d = divisor_i;
      cnt_d = cnt_t'(MAG_WIDTH);
      run_d = 1'b1;
    end else if (run_q) begin
      rem_d = ge ? sub[MAG_WIDTH-1:0] : shifted[MAG_WIDTH-1:0];
      quo_d = {quo_q[MAG_WIDTH-2:0], ge};
      cnt_d = cnt_q - cnt_t'(1);
      if (cnt_q == cnt_t'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    cnt_q <= cnt_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule
`default_nettype wire

>>> src/fraction_validate_and_reduce_core.sv
// Top level of the fraction validation and reduction core with its sequencer.
//
// An item is taken when start is high and busy is low. A fraction with a negative
// numerator or a denominator that is not positive gives 0/0 with is_empty_o set, and
// a zero numerator gives 0/d; both appear on valid_o in the cycle after the item is
// taken. Any other item runs a binary GCD on one shared subtractor, one step per
// cycle, and then one restoring divider divides the numerator and then the
// denominator by the GCD. The result is shown for exactly one cycle under valid_o
// and must be taken then; busy drops in that same cycle.
`default_nettype none
module fraction_validate_and_reduce_core
  import fvr_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   start,
  output logic   busy,
  input  value_t num_in_i,
  input  value_t den_in_i,
  output logic   valid_o,
  output mag_t   num_out_o,
  output mag_t   den_out_o,
  output logic   is_empty_o
);

  fvr_state_e state_q, state_d;
  mag_t       n_q, n_d;
  mag_t       d_q, d_d;
  mag_t       num_q, num_d;
  mag_t       den_q, den_d;
  logic       empty_q, empty_d;
  logic       valid_q, valid_d;

  logic       accept;
  logic       invalid;
  logic       num_zero;
  logic       gcd_start;
  logic       gcd_done;
  mag_t       gcd_g;
  logic       div_start;
  mag_t       div_dividend;
  logic       div_done;
  mag_t       div_quot;

  assign accept   = start && (state_q == ST_IDLE);
  assign invalid  = num_in_i[VALUE_WIDTH-1] || den_in_i[VALUE_WIDTH-1] || (den_in_i == '0);
  assign num_zero = (num_in_i[MAG_WIDTH-1:0] == '0);

  fvr_gcd u_gcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (gcd_start),
    .a_i     (num_in_i[MAG_WIDTH-1:0]),
    .b_i     (den_in_i[MAG_WIDTH-1:0]),
    .done_o  (gcd_done),
    .g_o     (gcd_g)
  );

  fvr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (gcd_g),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && !invalid && !num_zero) begin
          state_d = ST_GCD;
        end
      end
      ST_GCD: begin
        if (gcd_done) begin
          state_d = ST_DIV_NUM;
        end
      end
      ST_DIV_NUM: begin
        if (div_done) begin
          state_d = ST_DIV_DEN;
        end
      end
      ST_DIV_DEN: begin
        if (div_done) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    n_d          = n_q;
    d_d          = d_q;
    num_d        = num_q;
    den_d        = den_q;
    empty_d      = empty_q;
    valid_d      = 1'b0;
    gcd_start    = 1'b0;
    div_start    = 1'b0;
    div_dividend = d_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          n_d = num_in_i[MAG_WIDTH-1:0];
          d_d = den_in_i[MAG_WIDTH-1:0];
          if (invalid) begin
            num_d   = '0;
            den_d   = '0;
            empty_d = 1'b1;
            valid_d = 1'b1;
          end else if (num_zero) begin
            num_d   = '0;
            den_d   = den_in_i[MAG_WIDTH-1:0];
            empty_d = 1'b0;
            valid_d = 1'b1;
          end else begin
            gcd_start = 1'b1;
          end
        end
      end
      ST_GCD: begin
        div_dividend = n_q;
        div_start    = gcd_done;
      end
      ST_DIV_NUM: begin
        div_dividend = d_q;
        if (div_done) begin
          num_d     = div_quot;
          div_start = 1'b1;
        end
      end
      ST_DIV_DEN: begin
        if (div_done) begin
          den_d   = div_quot;
          empty_d = 1'b0;
          valid_d = 1'b1;
        end
      end
      default: begin
        valid_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    d_q     <= d_d;
    num_q   <= num_d;
    den_q   <= den_d;
    empty_q <= empty_d;
  end

  assign busy       = (state_q != ST_IDLE);
  assign valid_o    = valid_q;
  assign num_out_o  = num_q;
  assign den_out_o  = den_q;
  assign is_empty_o = empty_q;

endmodule
`default_nettype wire

>>> dv/testbench.sv
// Self-checking testbench for the fraction validation and reduction core.
`timescale 1ns / 1ps
module testbench;
  import fvr_pkg::*;

  typedef struct packed {
    mag_t num;
    mag_t den;
    logic empty;
  } frac_t;

  typedef struct packed {
    value_t num;
    value_t den;
    bit     known;
    frac_t  want;
  } stim_row_t;

  localparam int NUM_ROWS = 20;
  localparam int NUM_RANDOM = 1100;
  localparam mag_t MAG_MAX = '1;
  localparam frac_t EMPTY_FRAC = '{num: '0, den: '0, empty: 1'b1};

  localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    '{32'h0000_0000, 32'h0000_0001, 1'b1, '{31'd0, 31'd1, 1'b0}},
    '{32'h0000_0000, 32'h7fff_ffff, 1'b1, '{31'd0, MAG_MAX, 1'b0}},
    '{32'h0000_0000, 32'h0000_0000, 1'b1, EMPTY_FRAC},
    '{32'h0000_0001, 32'h0000_0000, 1'b1, EMPTY_FRAC},
    '{32'h0000_0005, 32'hffff_ffff, 1'b1, EMPTY_FRAC},
    '{32'h8000_0000, 32'h0000_0001, 1'b1, EMPTY_FRAC},
    '{32'hffff_ffff, 32'h0000_0003, 1'b1, EMPTY_FRAC},
    '{32'h7fff_ffff, 32'h8000_0000, 1'b1, EMPTY_FRAC},
    '{32'h8000_0000, 32'h8000_0000, 1'b1, EMPTY_FRAC},
    '{32'h0000_0000, 32'hffff_ffff, 1'b1, EMPTY_FRAC},
    '{32'h7fff_ffff, 32'h7fff_ffff, 1'b1, '{31'd1, 31'd1, 1'b0}},
    '{32'h7fff_ffff, 32'h0000_0001, 1'b1, '{MAG_MAX, 31'd1, 1'b0}},
    '{32'h0000_0001, 32'h7fff_ffff, 1'b1, '{31'd1, MAG_MAX, 1'b0}},
    '{32'h0000_0001, 32'h0000_0001, 1'b1, '{31'd1, 31'd1, 1'b0}},
    '{32'h0000_0006, 32'h0000_0004, 1'b1, '{31'd3, 31'd2, 1'b0}},
    '{32'h4000_0000, 32'h2000_0000, 1'b1, '{31'd2, 31'd1, 1'b0}},
    '{32'h7fff_fffe, 32'h7fff_ffff, 1'b0, '0},
    '{32'h5555_5555, 32'h2aaa_aaaa, 1'b0, '0},
    '{32'h0000_b520, 32'h0001_2511, 1'b0, '0},
    '{32'h1234_5678, 32'h09ab_cdef, 1'b0, '0}
  };

  logic   clk_i;
  logic   rst_ni;
  logic   start;
  logic   busy;
  value_t num_in_i;
  value_t den_in_i;
  logic   valid_o;
  mag_t   num_out_o;
  mag_t   den_out_o;
  logic   is_empty_o;

  frac_t expected_fracs[$];
  int    mismatch_count = 0;
  bit    idle_on = 1'b1;

  fraction_validate_and_reduce_core DUT (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .busy      (busy),
    .num_in_i  (num_in_i),
    .den_in_i  (den_in_i),
    .valid_o   (valid_o),
    .num_out_o (num_out_o),
    .den_out_o (den_out_o),
    .is_empty_o(is_empty_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic frac_t reduce_fraction(value_t n, value_t d);
    frac_t  r;
    value_t a;
    value_t b;
    value_t t;
    r = EMPTY_FRAC;
    if (n[VALUE_WIDTH-1] || d[VALUE_WIDTH-1] || d == '0) begin
      return r;
    end
    a = n;
    b = d;
    if (n == '0) begin
      a = value_t'(1);
    end else begin
      while (b != '0) begin
        t = a % b;
        a = b;
        b = t;
      end
    end
    r.num = mag_t'(n / a);
    r.den = mag_t'(d / a);
    r.empty = 1'b0;
    return r;
  endfunction

  // Offers one item after a random gap and holds it until the core takes it.
  task automatic issue_fraction(input value_t n, input value_t d, input frac_t want);
    int gap;
    if ($urandom_range(0, 39) == 0) begin
      idle_on = !idle_on;
    end
    gap = idle_on ? $urandom_range(0, 12) : 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    num_in_i <= n;
    den_in_i <= d;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    expected_fracs.push_back(want);
  endtask

  task automatic wait_drained(input int limit);
    int waited;
    waited = 0;
    start <= 1'b0;
    while (expected_fracs.size() != 0 && waited < limit) begin
      @(posedge clk_i);
      waited++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      if (expected_fracs.size() == 0) begin
        $display("%0t: result with no item pending: %0h/%0h empty %0b", $time,
                 num_out_o, den_out_o, is_empty_o);
        mismatch_count++;
      end else begin
        frac_t want;
        want = expected_fracs.pop_front();
        if (num_out_o !== want.num) begin
          $display("%0t: num_out expected %0h got %0h", $time, want.num, num_out_o);
          mismatch_count++;
        end
        if (den_out_o !== want.den) begin
          $display("%0t: den_out expected %0h got %0h", $time, want.den, den_out_o);
          mismatch_count++;
        end
        if (is_empty_o !== want.empty) begin
          $display("%0t: is_empty expected %0b got %0b", $time, want.empty, is_empty_o);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    value_t n;
    value_t d;
    value_t g;
    frac_t  want;
    rst_ni = 1'b0;
    start = 1'b0;
    num_in_i = '0;
    den_in_i = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED_ROWS[i]) begin
      want = DIRECTED_ROWS[i].known ? DIRECTED_ROWS[i].want
                                    : reduce_fraction(DIRECTED_ROWS[i].num, DIRECTED_ROWS[i].den);
      issue_fraction(DIRECTED_ROWS[i].num, DIRECTED_ROWS[i].den, want);
    end
    wait_drained(5000);

    for (int i = 0; i < NUM_RANDOM; i++) begin
      case ($urandom_range(0, 9))
        0: begin
          n = $urandom;
          d = $urandom;
        end
        1: begin
          n = $urandom;
          d = $urandom;
          if ($urandom_range(0, 1) == 1) begin
            n[VALUE_WIDTH-1] = 1'b1;
          end else if ($urandom_range(0, 1) == 1) begin
            d = '0;
          end else begin
            d[VALUE_WIDTH-1] = 1'b1;
          end
        end
        2, 3, 4, 5: begin
          g = $urandom_range(1, 2000);
          n = value_t'($urandom_range(0, 32'h7fff_ffff / g)) * g;
          d = value_t'($urandom_range(1, 32'h7fff_ffff / g)) * g;
        end
        6, 7: begin
          n = {1'b0, mag_t'($urandom)};
          d = {1'b0, mag_t'($urandom)};
          if (d == '0) begin
            d = value_t'(1);
          end
        end
        8: begin
          n = $urandom_range(0, 64);
          d = $urandom_range(0, 64);
        end
        default: begin
          n = $urandom >> $urandom_range(1, 31);
          d = value_t'(1) << $urandom_range(0, 30);
        end
      endcase
      issue_fraction(n, d, reduce_fraction(n, d));
      if (i == NUM_RANDOM / 2) begin
        wait_drained(5000);
      end
    end

    wait_drained(5000);
    repeat (140) @(posedge clk_i);
    if (expected_fracs.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_fracs.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end

endmodule
